// ----- src/packet_receiver_crc16_retx_check_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the packet receiver
// Shorthand for clocked, reset-qualified concurrent checks
// ----------------------------------------------------------------------------
`ifndef PACKET_RECEIVER_CRC16_RETX_CHECK_ASSERT_SVH
`define PACKET_RECEIVER_CRC16_RETX_CHECK_ASSERT_SVH

// same-cycle implication
`define PRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// Packet receiver package
// Types, register map, reset values and the byte-wide CRC-16/XMODEM update
// ----------------------------------------------------------------------------
package prc_pkg;

  // framing defaults
  localparam int unsigned PayloadBytesDefault = 29;

  // crc polynomial, init is zero
  localparam logic [15:0] CrcPoly = 16'h1021;

  // metadata length field of a retransmit request
  localparam logic [4:0] RetxLength = 5'd1;

  // register map (word index)
  localparam int unsigned AddrWidth = 4;
  localparam logic [1:0] RegCtrlType  = 2'd0;
  localparam logic [1:0] RegRetxOp    = 2'd1;
  localparam logic [1:0] RegPadValue  = 2'd2;

  // register reset values
  localparam logic [2:0] CtrlTypeReset = 3'd0;
  localparam logic [7:0] RetxOpReset   = 8'd0;
  localparam logic [7:0] PadValueReset = 8'hFF;

  // framing phase
  typedef enum logic [1:0] {
    PH_META    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC     = 2'd2
  } phase_e;

  // reported event
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_DATA    = 2'd1,
    EV_CRC_ERR = 2'd2,
    EV_RETX    = 2'd3
  } event_e;

  // one byte through the msb-first crc shift register
  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/packet_receiver_crc16_retx_check.sv -----
// ----------------------------------------------------------------------------
// Fixed-length packet receiver with CRC-16/XMODEM check
// Frames metadata, payload and crc bytes, reports data, crc error or retx
// ----------------------------------------------------------------------------
// Each accepted byte produces a result word, registered together with the
// framing state. Throughput: one byte per cycle while the result register is
// free or draining; the byte-wide crc update feeds the framing state registers.
// Reset (rst_ni low, asynchronous): framing restarts at the metadata byte,
// registers return to defaults and the result register empties.
module packet_receiver_crc16_retx_check #(
  parameter int unsigned PayloadBytes = prc_pkg::PayloadBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // received byte channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     event_res_o,
  output logic [2:0]                     packet_type_o,
  output logic [4:0]                     packet_length_o,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [prc_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import prc_pkg::*;

  localparam int unsigned IdxW = $clog2(PayloadBytes);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PayloadBytes - 1);

  // configuration registers
  logic [2:0] ctrl_type_q;
  logic [7:0] retx_op_q;
  logic [7:0] pad_value_q;
  logic       cfg_write;
  logic [1:0] cfg_index;

  // framing state
  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crc_low_q, crc_low_d;
  logic [7:0]      header_q, header_d;
  logic            match_q, match_d;

  // result register
  logic       out_valid_q;
  event_e     event_q, event_d;
  logic [2:0] type_q, type_d;
  logic [4:0] length_q, length_d;

  logic       in_accept;
  logic [7:0] want_byte;

  // register port
  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_type_q <= CtrlTypeReset;
      retx_op_q   <= RetxOpReset;
      pad_value_q <= PadValueReset;
    end else if (cfg_write) begin
      case (cfg_index)
        RegCtrlType: ctrl_type_q <= pwdata[2:0];
        RegRetxOp:   retx_op_q   <= pwdata[7:0];
        RegPadValue: pad_value_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_index)
      RegCtrlType: prdata = {29'd0, ctrl_type_q};
      RegRetxOp:   prdata = {24'd0, retx_op_q};
      RegPadValue: prdata = {24'd0, pad_value_q};
      default:     prdata = 32'd0;
    endcase
  end

  // a byte enters when the result register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // expected byte of a retransmit request payload
  assign want_byte = (idx_q == '0) ? retx_op_q : pad_value_q;

  // per-byte framing step
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    crc_d     = crc_q;
    crc_low_d = crc_low_q;
    header_d  = header_q;
    match_d   = match_q;
    event_d   = EV_NONE;
    type_d    = 3'd0;
    length_d  = 5'd0;
    case (phase_q)
      PH_PAYLOAD: begin
        crc_d = crc16_add(crc_q, rx_byte_i);
        if (rx_byte_i != want_byte) begin
          match_d = 1'b0;
        end
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          phase_d = PH_CRC;
        end else begin
          idx_d = IdxW'(idx_q + 1'b1);
        end
      end
      PH_CRC: begin
        if (idx_q == '0) begin
          crc_low_d = rx_byte_i;
          idx_d     = IdxW'(1);
        end else begin
          if ({rx_byte_i, crc_low_q} != crc_q) begin
            event_d = EV_CRC_ERR;
          end else if (match_q) begin
            event_d = EV_RETX;
          end else begin
            event_d = EV_DATA;
          end
          type_d   = header_q[7:5];
          length_d = header_q[4:0];
          idx_d    = '0;
          phase_d  = PH_META;
        end
      end
      default: begin
        // metadata byte, also taken for the unused phase code
        header_d = rx_byte_i;
        crc_d    = crc16_add(16'h0000, rx_byte_i);
        match_d  = (rx_byte_i == {ctrl_type_q, RetxLength});
        idx_d    = '0;
        phase_d  = PH_PAYLOAD;
      end
    endcase
  end

  // framing state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_META;
      idx_q     <= '0;
      crc_q     <= 16'h0000;
      crc_low_q <= 8'h00;
      header_q  <= 8'h00;
      match_q   <= 1'b1;
    end else if (in_accept) begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      crc_q     <= crc_d;
      crc_low_q <= crc_low_d;
      header_q  <= header_d;
      match_q   <= match_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      event_q  <= event_d;
      type_q   <= type_d;
      length_q <= length_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = event_q;
  assign packet_type_o   = type_q;
  assign packet_length_o = length_q;

  // checks
  `include "packet_receiver_crc16_retx_check_assert.svh"

  `PRC_ASSERT_NOW(a_none_fields_zero, out_valid_o && (event_q == EV_NONE), (packet_type_o == 3'd0) && (packet_length_o == 5'd0), "fields set without an event")
  `PRC_ASSERT_NEXT(a_crc_end_reports, in_accept && (phase_q == PH_CRC) && (idx_q != '0), out_valid_o && (event_q != EV_NONE), "packet end gave no event")
  `PRC_ASSERT_NEXT(a_payload_silent, in_accept && (phase_q == PH_PAYLOAD), out_valid_o && (event_q == EV_NONE), "event inside payload")
  `PRC_ASSERT_NOW(a_crc_idx_range, phase_q == PH_CRC, idx_q <= IdxW'(1), "crc byte index out of range")

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Packet receiver testbench
// Feeds framed and noisy byte streams through the receiver under random
// source gaps and sink stalls. A built-in framing and crc tracker predicts
// the result word for every accepted byte, and the result words are checked
// in order. Register settings change only between traffic phases.
// ----------------------------------------------------------------------------
module tb;
  import prc_pkg::*;

  localparam int unsigned PAYLOAD_LEN = PayloadBytesDefault;
  localparam int unsigned PKT_BYTES   = PAYLOAD_LEN + 3;
  localparam int unsigned LONG_HOLD   = 60;

  // one result word
  typedef struct packed {
    event_e     ev;
    logic [2:0] ptype;
    logic [4:0] plen;
  } pkt_result_t;

  // payload shapes and checksum faults used by the packet builder
  typedef enum logic [2:0] {
    BODY_RETX, BODY_RETX_BAD_OP, BODY_RETX_BAD_PAD, BODY_ZERO, BODY_ONES, BODY_RANDOM
  } body_e;

  typedef enum logic [1:0] {SUM_GOOD, SUM_BAD_LO, SUM_BAD_HI} sum_e;

  typedef struct packed {
    logic [7:0]  meta;
    body_e       body;
    sum_e        sum;
    logic        typed;
    pkt_result_t want;
  } pkt_case_t;

  // directed packets at reset settings: control type 0, opcode 0x00, pad 0xFF
  localparam pkt_case_t DIRECTED [12] = '{
    '{8'h01, BODY_RETX,         SUM_GOOD,   1'b1, '{EV_RETX,    3'd0, 5'd1}},
    '{8'h01, BODY_RETX,         SUM_BAD_LO, 1'b1, '{EV_CRC_ERR, 3'd0, 5'd1}},
    '{8'h01, BODY_RETX,         SUM_BAD_HI, 1'b1, '{EV_CRC_ERR, 3'd0, 5'd1}},
    '{8'h01, BODY_RETX_BAD_OP,  SUM_GOOD,   1'b1, '{EV_DATA,    3'd0, 5'd1}},
    '{8'h01, BODY_RETX_BAD_PAD, SUM_GOOD,   1'b1, '{EV_DATA,    3'd0, 5'd1}},
    '{8'h21, BODY_RETX,         SUM_GOOD,   1'b1, '{EV_DATA,    3'd1, 5'd1}},
    '{8'h02, BODY_RETX,         SUM_GOOD,   1'b1, '{EV_DATA,    3'd0, 5'd2}},
    '{8'hFF, BODY_ONES,         SUM_GOOD,   1'b1, '{EV_DATA,    3'd7, 5'd31}},
    '{8'h00, BODY_ZERO,         SUM_GOOD,   1'b1, '{EV_DATA,    3'd0, 5'd0}},
    '{8'h00, BODY_ZERO,         SUM_BAD_LO, 1'b1, '{EV_CRC_ERR, 3'd0, 5'd0}},
    '{8'hA5, BODY_RANDOM,       SUM_GOOD,   1'b0, '{EV_NONE,    3'd0, 5'd0}},
    '{8'h5A, BODY_RANDOM,       SUM_BAD_HI, 1'b0, '{EV_NONE,    3'd0, 5'd0}}
  };

  // dut signals
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata      = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  event_res_o;
  logic [2:0]  packet_type_o;
  logic [4:0]  packet_length_o;
  logic [31:0] prdata;
  logic        pready;

  // register shadows
  logic [2:0] cfg_ctrl_type = CtrlTypeReset;
  logic [7:0] cfg_retx_op   = RetxOpReset;
  logic [7:0] cfg_pad       = PadValueReset;

  // framing tracker state
  phase_e      rx_phase    = PH_META;
  logic [4:0]  rx_pos      = '0;
  logic [15:0] crc_acc     = '0;
  logic [7:0]  crc_lo      = '0;
  logic [7:0]  meta_byte   = '0;
  logic        retx_so_far = 1'b1;

  pkt_result_t pending_results [$];
  int          mismatches   = 0;
  int          bytes_fed    = 0;
  int          src_gap_odds = 0;
  bit          calm         = 1'b0;
  int          hold_asked   = 0;
  int          hold_served  = 0;
  int          sink_hold    = 0;

  packet_receiver_crc16_retx_check #(
    .PayloadBytes(PAYLOAD_LEN)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_res_o     (event_res_o),
    .packet_type_o   (packet_type_o),
    .packet_length_o (packet_length_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // bit-serial crc-16/xmodem, one input bit per shift
  function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      if (r[15] ^ b[k]) begin
        r = {r[14:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // advance the framing tracker by one byte and produce its result word
  function automatic pkt_result_t frame_byte(input logic [7:0] b);
    pkt_result_t r;
    logic [7:0]  want;
    r = '0;
    r.ev = EV_NONE;
    case (rx_phase)
      PH_PAYLOAD: begin
        want = (rx_pos == 5'd0) ? cfg_retx_op : cfg_pad;
        crc_acc = crc_xmodem_byte(crc_acc, b);
        if (b != want) retx_so_far = 1'b0;
        rx_pos = rx_pos + 5'd1;
        if (int'(rx_pos) >= PAYLOAD_LEN || rx_pos == 5'd0) begin
          rx_pos = '0;
          rx_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        if (rx_pos == 5'd0) begin
          crc_lo = b;
          rx_pos = 5'd1;
        end else begin
          // checksum failure wins over a retransmit match
          if ({b, crc_lo} != crc_acc) r.ev = EV_CRC_ERR;
          else if (retx_so_far) r.ev = EV_RETX;
          else r.ev = EV_DATA;
          r.ptype = meta_byte[7:5];
          r.plen = meta_byte[4:0];
          rx_pos = '0;
          rx_phase = PH_META;
        end
      end
      default: begin
        meta_byte = b;
        crc_acc = crc_xmodem_byte(16'h0000, b);
        retx_so_far = (b == {cfg_ctrl_type, RetxLength});
        rx_pos = '0;
        rx_phase = PH_PAYLOAD;
      end
    endcase
    return r;
  endfunction

  // offer one byte, wait for it to be taken, then log its result
  task automatic push_byte(input logic [7:0] b, input bit typed, input pkt_result_t want);
    pkt_result_t r;
    if (!calm && src_gap_odds != 0 && $urandom_range(0, src_gap_odds) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    r = frame_byte(b);
    if (typed) r = want;
    pending_results.push_back(r);
    bytes_fed++;
  endtask

  // build one full packet with the requested payload shape and checksum fault
  task automatic send_packet(input logic [7:0] meta, input body_e body, input int flip_at,
                             input sum_e sum, input bit typed, input pkt_result_t want);
    logic [7:0]  pkt [PKT_BYTES];
    logic [15:0] crc;
    src_gap_odds = (calm || $urandom_range(0, 2) == 0) ? 0 : 5;
    pkt[0] = meta;
    crc = crc_xmodem_byte(16'h0000, meta);
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      case (body)
        BODY_RETX:         pkt[i+1] = (i == 0) ? cfg_retx_op : cfg_pad;
        BODY_RETX_BAD_OP:  pkt[i+1] = (i == 0) ? ~cfg_retx_op : cfg_pad;
        BODY_RETX_BAD_PAD: pkt[i+1] = (i == 0) ? cfg_retx_op :
                                      (i == PAYLOAD_LEN - 1) ? ~cfg_pad : cfg_pad;
        BODY_ZERO:         pkt[i+1] = 8'h00;
        BODY_ONES:         pkt[i+1] = 8'hFF;
        default:           pkt[i+1] = 8'($urandom);
      endcase
      if (i == flip_at) pkt[i+1] = pkt[i+1] ^ 8'($urandom_range(1, 255));
      crc = crc_xmodem_byte(crc, pkt[i+1]);
    end
    pkt[PAYLOAD_LEN+1] = crc[7:0];
    pkt[PAYLOAD_LEN+2] = crc[15:8];
    if (sum == SUM_BAD_LO) pkt[PAYLOAD_LEN+1] ^= 8'($urandom_range(1, 255));
    if (sum == SUM_BAD_HI) pkt[PAYLOAD_LEN+2] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < PKT_BYTES; i++) begin
      push_byte(pkt[i], typed && (i == PKT_BYTES - 1), want);
    end
  endtask

  // mostly well-formed packets, with stray bytes that knock framing off
  task automatic run_traffic(input int n_bytes);
    int         stop_at;
    logic [7:0] meta;
    body_e      body;
    sum_e       sum;
    int         flip_at;
    stop_at = bytes_fed + n_bytes;
    while (bytes_fed < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom), 1'b0, '0);
      end
      // resync on random bytes until the next metadata byte is due
      while (rx_phase != PH_META) push_byte(8'($urandom), 1'b0, '0);
      case ($urandom_range(0, 3))
        0, 1:    meta = {cfg_ctrl_type, RetxLength};
        2:       meta = {cfg_ctrl_type, 5'($urandom)};
        default: meta = 8'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2: body = BODY_RETX;
        3:       body = BODY_RETX_BAD_OP;
        4:       body = BODY_RETX_BAD_PAD;
        5:       body = ($urandom_range(0, 1) == 0) ? BODY_ZERO : BODY_ONES;
        default: body = BODY_RANDOM;
      endcase
      flip_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, PAYLOAD_LEN - 1)) : -1;
      case ($urandom_range(0, 7))
        6:       sum = SUM_BAD_LO;
        7:       sum = SUM_BAD_HI;
        default: sum = SUM_GOOD;
      endcase
      send_packet(meta, body, flip_at, sum, 1'b0, '0);
    end
  endtask

  // stop offering and wait until every result word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // register write: setup cycle then access cycle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_config(input logic [2:0] ctype, input logic [7:0] op, input logic [7:0] pad);
    reg_write(RegCtrlType, 32'(ctype));
    reg_write(RegRetxOp, 32'(op));
    reg_write(RegPadValue, 32'(pad));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_ctrl_type = ctype;
    cfg_retx_op = op;
    cfg_pad = pad;
  endtask

  // sink: random stall bursts, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready_i <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      sink_hold = LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_hold = $urandom_range(0, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result word checker
  always @(posedge clk_i) begin
    pkt_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result word: event %0d type %0d length %0d",
                   event_res_o, packet_type_o, packet_length_o);
        end
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (event_res_o !== exp_r.ev || packet_type_o !== exp_r.ptype ||
            packet_length_o !== exp_r.plen) begin
          if (mismatches < 10) begin
            $display("mismatch: event %0d/%0d type %0d/%0d length %0d/%0d (exp/got)",
                     exp_r.ev, event_res_o, exp_r.ptype, packet_type_o,
                     exp_r.plen, packet_length_o);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #4800000;
    $display("RESULT: ERROR");
    $finish;
  end

  // main sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed packets at reset settings
    foreach (DIRECTED[i]) begin
      send_packet(DIRECTED[i].meta, DIRECTED[i].body, -1, DIRECTED[i].sum,
                  DIRECTED[i].typed, DIRECTED[i].want);
    end
    run_traffic(200);

    // random traffic under several register settings
    for (int ph = 1; ph <= 4; ph++) begin
      drain();
      case (ph)
        1:       set_config(3'd7, 8'hFF, 8'h00);
        2:       set_config(3'($urandom), 8'($urandom), 8'($urandom));
        3:       set_config(3'd3, 8'h80, 8'h7F);
        default: begin
          set_config(CtrlTypeReset, RetxOpReset, PadValueReset);
          calm = 1'b1;
        end
      endcase
      // long sink hold-off while the source keeps offering
      if (ph == 1) hold_asked++;
      run_traffic(110);
      // source pauses until the pipe is empty
      if (ph == 2) drain();
      run_traffic(110);
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
